### rtl/std_pkg.sv
`default_nettype none
package std_pkg;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [2:0] CFG_POLICY = 3'd0;
  localparam logic [2:0] CFG_TRACKED = 3'd1;
  localparam logic [2:0] CFG_ILV_MODE = 3'd2;
  localparam logic [2:0] CFG_ILV_COUNT = 3'd3;
  localparam logic [2:0] CFG_OFFSET = 3'd4;

  localparam logic [1:0] CMD_FIND = 2'd0;
  localparam logic [1:0] CMD_ACCESS = 2'd1;
  localparam logic [1:0] CMD_SET = 2'd2;

  localparam logic [1:0] POL_LRU = 2'd0;
  localparam logic [1:0] POL_FIFO = 2'd1;

  localparam logic [1:0] ST_UNTRACKED = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_HIT = 2'd2;
  localparam logic [1:0] ST_WRITTEN = 2'd3;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  typedef struct packed {
    logic [1:0] command;
    logic [31:0] address;
    logic [2:0] new_state;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] set_index;
    logic way_valid;
    logic [2:0] way_index;
    logic [31:0] block_tag;
  } out_word_t;
endpackage
`default_nettype wire

### rtl/std_if.sv
`default_nettype none
interface std_in_if;
  import std_pkg::*;
  logic valid;
  logic ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface std_out_if;
  import std_pkg::*;
  logic valid;
  logic ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/std_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module std_divider
  import std_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic [31:0] dividend,
  input wire logic [6:0] divisor,
  output logic done,
  output logic [31:0] quotient
);
  logic [31:0] q_r, q_nxt;
  logic [6:0] rem_r, rem_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [7:0] trial;

  always_comb begin
    trial = {rem_r, q_r[31]} - {1'b0, divisor};
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[7]) begin
        rem_nxt = trial[6:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[5:0], q_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd31);
  assign quotient = q_nxt;
endmodule
`default_nettype wire

### rtl/sampled_tag_directory_unit.sv
`default_nettype none
// From accept to out valid: an untracked set answers after the set index is formed, a tracked set
// scans its ways in turn up to a hit or the last way, a set that evicts under LRU/FIFO moves the victim
// to the head of the order list, an LRU access hit moves the hit way to the head; interleaved mode
// adds a serial divide first (one quotient bit per cycle). Flow control: one word in flight, ready
// only in idle; the next word is taken in the cycle after the result enters the output register,
// later if that register still holds an unaccepted word. Reset (synchronous, rst_n low): registers
// to defaults, LFSR to seed, then a clearing pass over all tag/state/order memory entries.
module sampled_tag_directory_unit
  import std_pkg::*;
#(
  parameter int unsigned WAYS = 8,
  parameter int unsigned DIRECTORY_SETS = 64,
  parameter int unsigned CACHE_SETS = 1024
) (
  input wire logic clk,
  input wire logic rst_n,
  std_in_if.sink in_ch,
  std_out_if.source out_ch,
  input wire logic cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SW = (DIRECTORY_SETS > 1) ? $clog2(DIRECTORY_SETS) : 1;
  localparam int unsigned CSW = (CACHE_SETS > 1) ? $clog2(CACHE_SETS) : 1;
  localparam int unsigned DEPTH = DIRECTORY_SETS * WAYS;
  localparam int unsigned AW = $clog2(DEPTH);

  // memories: one entry per (set, way); order holds way at list position
  logic [31:0] tag_mem [DEPTH];
  logic [2:0] st_mem [DEPTH];
  logic [WW-1:0] ord_mem [DEPTH];

  logic [1:0] pol_r;
  logic [6:0] trk_r, cnt_r;
  logic ilv_r;
  logic [3:0] off_r;
  logic [15:0] lfsr_r;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_SET, S_RD, S_CMP, S_DECIDE, S_FIND, S_FCMP,
    S_SHIFT_RD, S_SHIFT_WR, S_WRITE, S_OUT
  } state_t;
  state_t st_r;

  logic [AW:0] clr_r;
  in_word_t item_r;
  logic [31:0] tag_r, blk_r;
  logic [CSW-1:0] set_r;
  logic [WW:0] w_r;  // scan pointer
  logic hit_r;
  logic [WW-1:0] way_r;
  logic [31:0] rd_tag_r;
  logic [2:0] rd_st_r;
  logic [WW-1:0] rd_ord_r;
  logic [WW:0] pos_r;
  out_word_t res_r;
  out_word_t out_r;  // output register, frees the core for the next word
  logic ov_r;

  logic div_start, div_done;
  logic [31:0] div_q;
  logic [6:0] dcnt;
  assign dcnt = (cnt_r == 7'd0) ? 7'd1 : cnt_r;

  logic [31:0] omask, in_tag;
  assign omask = (32'd1 << off_r) - 32'd1;
  assign in_tag = in_ch.data.address & ~omask;

  // divide starts on the accepting edge, so it takes the incoming block number
  std_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(in_tag >> off_r),
    .divisor(dcnt), .done(div_done), .quotient(div_q)
  );

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data = out_r;

  logic [SW-1:0] sidx;
  assign sidx = set_r[SW-1:0];
  logic [AW-1:0] base;
  assign base = AW'(sidx) * AW'(WAYS);
  logic [AW-1:0] wa;
  assign wa = base + AW'(w_r[WW-1:0]);

  logic tracked;
  logic [31:0] lim;
  assign lim = (32'(trk_r) < 32'(DIRECTORY_SETS)) ? 32'(trk_r) : 32'(DIRECTORY_SETS);
  assign tracked = 32'(set_r) < lim;

  logic [15:0] lfsr_n;
  assign lfsr_n = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_MASK) : (lfsr_r >> 1);

  assign div_start = (st_r == S_IDLE) && in_ch.valid && ilv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
      ov_r <= 1'b0;
      pol_r <= 2'd0;
      trk_r <= 7'd64;
      ilv_r <= 1'b0;
      cnt_r <= 7'd1;
      off_r <= 4'd6;
      lfsr_r <= LFSR_SEED;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY: pol_r <= cfg_data[1:0];
          CFG_TRACKED: trk_r <= cfg_data;
          CFG_ILV_MODE: ilv_r <= cfg_data[0];
          CFG_ILV_COUNT: cnt_r <= cfg_data;
          CFG_OFFSET: off_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      // load the output register when it is free or drains this cycle
      if (st_r == S_OUT && (!ov_r || out_ch.ready)) begin
        ov_r <= 1'b1;
        out_r <= res_r;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        S_CLEAR: begin
          tag_mem[clr_r[AW-1:0]] <= '0;
          st_mem[clr_r[AW-1:0]] <= '0;
          ord_mem[clr_r[AW-1:0]] <= WW'(32'(clr_r[AW-1:0]) % WAYS);
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == DEPTH - 1) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            item_r <= in_ch.data;
            tag_r <= in_tag;
            blk_r <= in_tag >> off_r;
            st_r <= ilv_r ? S_DIV : S_SET;
          end
        end
        S_DIV: if (div_done) begin
          blk_r <= div_q;
          st_r <= S_SET;
        end
        S_SET: begin
          set_r <= CSW'(blk_r % CACHE_SETS);
          w_r <= '0;
          hit_r <= 1'b0;
          way_r <= '0;
          st_r <= S_RD;
        end
        S_RD: begin
          if (!tracked) begin
            res_r <= '{ST_UNTRACKED, 10'(set_r), 1'b0, 3'd0, tag_r};
            st_r <= S_OUT;
          end else begin
            rd_tag_r <= tag_mem[wa];
            rd_st_r <= st_mem[wa];
            st_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_tag_r == tag_r && rd_st_r != 3'd0) begin
            hit_r <= 1'b1;
            way_r <= w_r[WW-1:0];
            st_r <= S_DECIDE;
          end else if (32'(w_r) == WAYS - 1) begin
            st_r <= S_DECIDE;
          end else begin
            w_r <= w_r + 1'b1;
            st_r <= S_RD;
          end
        end
        S_DECIDE: begin
          // victim / recency decisions
          if (item_r.command == CMD_SET) begin
            if (!hit_r) begin
              if (pol_r == POL_LRU || pol_r == POL_FIFO) begin
                way_r <= ord_mem[base + AW'(WAYS - 1)];
                pos_r <= (WW+1)'(WAYS - 1);
                st_r <= S_SHIFT_RD;
              end else begin
                lfsr_r <= lfsr_n;
                way_r <= WW'(32'(lfsr_n) % WAYS);
                w_r <= (WW+1)'(32'(lfsr_n) % WAYS);
                st_r <= S_WRITE;
              end
            end else begin
              w_r <= {1'b0, way_r};
              st_r <= S_WRITE;
            end
          end else if (hit_r && item_r.command == CMD_ACCESS && pol_r == POL_LRU) begin
            pos_r <= '0;
            st_r <= S_FIND;
          end else begin
            res_r <= '{hit_r ? ST_HIT : ST_MISS, 10'(set_r), hit_r,
                       hit_r ? 3'(way_r) : 3'd0, tag_r};
            st_r <= S_OUT;
          end
        end
        S_FIND: begin
          // locate way_r in order list
          rd_ord_r <= ord_mem[base + AW'(pos_r[WW-1:0])];
          st_r <= S_FCMP;
        end
        S_FCMP: begin
          if (rd_ord_r == way_r) begin
            st_r <= S_SHIFT_RD;
          end else begin
            pos_r <= pos_r + 1'b1;
            st_r <= S_FIND;
          end
        end
        S_SHIFT_RD: begin
          if (pos_r == '0) begin
            ord_mem[base] <= way_r;
            if (item_r.command == CMD_SET) begin
              // victim now at head, go write it
              w_r <= {1'b0, way_r};
              st_r <= S_WRITE;
            end else begin
              res_r <= '{ST_HIT, 10'(set_r), 1'b1, 3'(way_r), tag_r};
              st_r <= S_OUT;
            end
          end else begin
            rd_ord_r <= ord_mem[base + AW'(pos_r[WW-1:0] - 1'b1)];
            st_r <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          ord_mem[base + AW'(pos_r[WW-1:0])] <= rd_ord_r;
          pos_r <= pos_r - 1'b1;
          st_r <= S_SHIFT_RD;
        end
        S_WRITE: begin
          // FIFO reorder on a tag change never moves anything here: a hit keeps
          // its tag and an LRU/FIFO victim already sits at the head
          tag_mem[wa] <= tag_r;
          st_mem[wa] <= item_r.new_state;
          res_r <= '{ST_WRITTEN, 10'(set_r), 1'b1, 3'(way_r), tag_r};
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (!ov_r || out_ch.ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
